// File: src/sct_pkg.sv
// ----------------------------------------------------------------------------
// Sector chain table package
// Shared constants and types for the sector chain table engine.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int TableDepth = 131072;
   localparam int AddrW      = $clog2(TableDepth);
   localparam int CntW       = AddrW + 1;
   localparam int QueueDepth = 2;

   localparam logic [31:0] CODE_EOF  = 32'hFFFF_FFFE;
   localparam logic [31:0] CODE_FREE = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_LAST  = 2'd2,
      FUNC_INDEX = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFREE  = 2'd1,
      ST_BROKEN  = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   // classified item handed from the front end to the back end
   typedef struct packed {
      func_type    func;
      logic [31:0] sector;
      logic [17:0] hops;
      logic        sec_valid;   // sector < n at acceptance
      logic        hops_zero;
   } cmd_type;

endpackage

// File: src/sct_front.sv
// ----------------------------------------------------------------------------
// Sector chain table front end
// Accepts request items, classifies them, and queues them for the back end.
// ----------------------------------------------------------------------------
module sct_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [31:0]          req_sector,
   input  logic [17:0]          req_hop_index,
   input  logic [sct_pkg::CntW-1:0] count_n,
   output logic                 cmd_valid,
   input  logic                 cmd_take,
   output sct_pkg::cmd_type     cmd
);

   localparam int PtrW = $clog2(sct_pkg::QueueDepth);

   sct_pkg::cmd_type    queue_ff [sct_pkg::QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]       fill_ff, fill_in;
   logic                push, pop;
   sct_pkg::cmd_type    new_cmd;

   assign req_stall = (fill_ff == (PtrW+1)'(sct_pkg::QueueDepth));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.func      = sct_pkg::func_type'(req_func);
      new_cmd.sector    = req_sector;
      new_cmd.hops      = req_hop_index;
      new_cmd.sec_valid = req_sector < 32'(count_n);
      new_cmd.hops_zero = (req_hop_index == '0);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= new_cmd;
   end

   overflow_chk: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (PtrW+1)'(sct_pkg::QueueDepth))
      else $error("queue fill above depth");
   no_push_full: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == (PtrW+1)'(sct_pkg::QueueDepth)) |-> !push)
      else $error("push into full queue");
   fill_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("fill count lost a push");

endmodule

// File: src/sct_back.sv
// ----------------------------------------------------------------------------
// Sector chain table back end
// Runs queued items against the link table: scans, walks and relinks.
// ----------------------------------------------------------------------------
module sct_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [sct_pkg::CntW-1:0] count_n,
   input  logic                     cmd_valid,
   output logic                     cmd_take,
   input  sct_pkg::cmd_type         cmd,
   output logic                     clearing,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [31:0]              rsp_result_sector,
   output logic [17:0]              rsp_chain_length
);

   localparam int AW = sct_pkg::AddrW;
   localparam int CW = sct_pkg::CntW;

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b000_0000_0001,
      S_IDLE   = 11'b000_0000_0010,
      S_SREAD  = 11'b000_0000_0100,  // scan: issue read
      S_SCHK   = 11'b000_0000_1000,  // scan: check data
      S_WREAD  = 11'b000_0001_0000,
      S_WCHK   = 11'b000_0010_0000,
      S_FTGT   = 11'b000_0100_0000,  // free: read target link
      S_FCHK   = 11'b000_1000_0000,
      S_FSCAN  = 11'b001_0000_0000,  // free: relink pass
      S_FSCHK  = 11'b010_0000_0000,
      S_DONE   = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [31:0]       mem [sct_pkg::TableDepth];
   logic [31:0]       rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [31:0]       wr_data;

   sct_pkg::cmd_type  cmd_ff, cmd_in;
   logic [CW-1:0]     idx_ff, idx_in;      // scan index or hop count
   logic [CW-1:0]     cnt_ff, cnt_in;      // walk length
   logic [31:0]       cur_ff, cur_in;      // walk position
   logic [31:0]       fr_ff, fr_in;        // free entry, or target link
   logic              out_v_ff, out_v_in;
   logic [1:0]        st_ff, st_in;
   logic [31:0]       res_ff, res_in;
   logic [17:0]       len_ff, len_in;
   logic [31:0]       n32;

   assign n32               = 32'(count_n);
   assign clearing          = (state_ff == S_CLEAR);
   assign rsp_valid         = out_v_ff;
   assign rsp_status        = st_ff;
   assign rsp_result_sector = res_ff;
   assign rsp_chain_length  = len_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      cur_in   = cur_ff;
      fr_in    = fr_ff;
      out_v_in = out_v_ff && rsp_stall;
      st_in    = st_ff;
      res_in   = res_ff;
      len_in   = len_ff;
      cmd_take = 1'b0;
      rd_addr  = cur_ff[AW-1:0];
      wr_en    = 1'b0;
      wr_addr  = cur_ff[AW-1:0];
      wr_data  = sct_pkg::CODE_EOF;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = sct_pkg::CODE_FREE;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == CW'(sct_pkg::TableDepth - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            // result registers are reused, so wait until the last item has left
            if (cmd_valid && (!out_v_ff || !rsp_stall)) begin
               cmd_take = 1'b1;
               cmd_in   = cmd;
               idx_in   = '0;
               cnt_in   = CW'(1);
               cur_in   = cmd.sector;
               st_in    = sct_pkg::ST_OK;
               res_in   = sct_pkg::CODE_EOF;
               len_in   = '0;
               unique case (cmd.func)
                  sct_pkg::FUNC_ALLOC: state_in = S_SREAD;
                  sct_pkg::FUNC_FREE: begin
                     if (cmd.sec_valid) state_in = S_FTGT;
                     else begin
                        st_in    = sct_pkg::ST_INVALID;
                        state_in = S_DONE;
                     end
                  end
                  sct_pkg::FUNC_LAST: begin
                     if (cmd.sec_valid) state_in = S_WREAD;
                     else begin
                        st_in    = sct_pkg::ST_INVALID;
                        state_in = S_DONE;
                     end
                  end
                  sct_pkg::FUNC_INDEX: begin
                     res_in   = cmd.sector;
                     state_in = cmd.hops_zero ? S_DONE : S_WREAD;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SREAD: begin
            if (idx_ff >= count_n) begin
               st_in    = sct_pkg::ST_NOFREE;
               state_in = S_DONE;
            end else begin
               rd_addr  = idx_ff[AW-1:0];
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            if (rd_data_ff == sct_pkg::CODE_FREE) begin
               fr_in = 32'(idx_ff);
               if (cmd_ff.sec_valid) state_in = S_WREAD;
               else begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff[AW-1:0];
                  res_in   = 32'(idx_ff);
                  state_in = S_DONE;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SREAD;
            end
         end
         S_WREAD: begin
            if (cmd_ff.func == sct_pkg::FUNC_INDEX && cur_ff >= n32) begin
               res_in   = sct_pkg::CODE_EOF;
               state_in = S_DONE;
            end else begin
               rd_addr  = cur_ff[AW-1:0];
               state_in = S_WCHK;
            end
         end
         S_WCHK: begin
            if (cmd_ff.func == sct_pkg::FUNC_INDEX) begin
               cur_in = rd_data_ff;
               res_in = rd_data_ff;
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == CW'(cmd_ff.hops)) ? S_DONE : S_WREAD;
            end else if (rd_data_ff == sct_pkg::CODE_EOF) begin
               if (cmd_ff.func == sct_pkg::FUNC_LAST) begin
                  res_in = cur_ff;
                  len_in = 18'(cnt_ff);
               end else begin
                  // link tail to the new entry; EOF written next cycle
                  wr_en   = 1'b1;
                  wr_data = fr_ff;
                  res_in  = fr_ff;
                  cur_in  = fr_ff;
               end
               state_in = (cmd_ff.func == sct_pkg::FUNC_LAST) ? S_DONE : S_FSCHK;
            end else if (rd_data_ff >= n32 || cnt_ff >= count_n) begin
               st_in    = sct_pkg::ST_BROKEN;
               state_in = S_DONE;
            end else begin
               cur_in   = rd_data_ff;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_WREAD;
            end
         end
         S_FTGT: begin
            rd_addr  = cur_ff[AW-1:0];
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if ((rd_data_ff != sct_pkg::CODE_EOF && rd_data_ff >= n32)
                  || rd_data_ff == cmd_ff.sector) begin
               st_in    = sct_pkg::ST_BROKEN;
               state_in = S_DONE;
            end else begin
               fr_in    = rd_data_ff;
               idx_in   = '0;
               state_in = S_FSCAN;
            end
         end
         S_FSCAN: begin
            // each entry: read (S_FSCAN), then relink on match (S_FSCHK)
            if (idx_ff >= count_n) begin
               wr_en    = 1'b1;
               wr_data  = sct_pkg::CODE_FREE;
               res_in   = cmd_ff.sector;
               state_in = S_DONE;
            end else begin
               rd_addr  = idx_ff[AW-1:0];
               state_in = S_FSCHK;
            end
         end
         S_FSCHK: begin
            if (cmd_ff.func == sct_pkg::FUNC_ALLOC) begin
               // new entry becomes end of chain
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               if (rd_data_ff == cmd_ff.sector) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff[AW-1:0];
                  wr_data = fr_ff;
               end
               idx_in   = idx_ff + 1'b1;
               state_in = S_FSCAN;
            end
         end
         S_DONE: begin
            if (!out_v_ff || !rsp_stall) begin
               out_v_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         out_v_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cnt_ff <= cnt_in;
      cur_ff <= cur_in;
      fr_ff  <= fr_in;
      st_ff  <= st_in;
      res_ff <= res_in;
      len_ff <= len_in;
   end

   take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> state_ff == S_IDLE)
      else $error("item taken outside idle");
   no_take_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !cmd_take)
      else $error("item taken during clearing pass");
   done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !(out_v_ff && rsp_stall)) |=> rsp_valid)
      else $error("result not presented");
   hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_result_sector) && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

// File: src/sector_chain_table_engine.sv
// Allocate scans the table for a free entry and, for a valid sector, walks
// the chain to its tail; find last and index follow links; free does a full
// relink pass over the table. One item at a time in the back end.
// Reset: synchronous; a clearing pass writes FREE to every entry, during
// which no item is taken (register writes are).
// ----------------------------------------------------------------------------
// Sector chain table engine
// Link table manager: allocate, free, find last and index along chains.
// ----------------------------------------------------------------------------
module sector_chain_table_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_sector,
   input  logic [17:0] req_hop_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_sector,
   output logic [17:0] rsp_chain_length,
   input  logic        csr_we,
   input  logic [17:0] csr_wdata
);

   localparam int CW = sct_pkg::CntW;

   logic [17:0]       sectors_ff;
   logic [CW-1:0]     count_n;
   logic              cmd_valid, cmd_take, clearing, front_stall;
   sct_pkg::cmd_type  cmd;

   always_ff @(posedge clock) begin
      if (reset) sectors_ff <= 18'd131072;
      else if (csr_we) sectors_ff <= csr_wdata;
   end

   assign count_n = (32'(sectors_ff) > 32'(sct_pkg::TableDepth)) ?
                    CW'(sct_pkg::TableDepth) : CW'(sectors_ff);

   assign req_stall = front_stall || clearing;

   sct_front u_front (
      .clock, .reset,
      .req_valid(req_valid && !clearing),
      .req_stall(front_stall),
      .req_func, .req_sector, .req_hop_index,
      .count_n, .cmd_valid, .cmd_take, .cmd
   );

   sct_back u_back (
      .clock, .reset, .count_n, .cmd_valid, .cmd_take, .cmd, .clearing,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_result_sector,
      .rsp_chain_length
   );

endmodule
